[sv/cau_pkg.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared request/result types, opcodes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned TolWidth   = 31;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_EQ   = 3'd5,
    OP_NOP6 = 3'd6,
    OP_NOP7 = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2,
    ST_RSV  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic               are_equal;
    logic [1:0]         status;
  } res_t;

endpackage
`default_nettype wire

[sv/cau_queue.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit queue
// Small register FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0]    wr_q, rd_q;
  logic [Aw:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == Aw'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == Aw'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

[sv/cau_front.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Sign-extends operands, classifies the opcode, forms the partial products.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_front #(
  parameter int unsigned Dw = 32,
  parameter int unsigned Pw = 2*Dw+2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire cau_pkg::req_t in_req_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output logic [3*Pw+2:0]    out_data_o,
  input  wire logic          out_ready_i
);
  import cau_pkg::*;

  // Products are exact; the sums p0+q0 and p1+q1 go to the back end.
  logic signed [Dw-1:0]   ar, ai, br, bi;
  logic signed [2*Dw-1:0] ar_br, ai_bi, ar_bi, ai_br, br_br, bi_bi;
  logic signed [Pw-1:0]   p0, q0, p1, q1, den;
  logic                   valid_q;
  logic [2:0]             op_q;
  logic signed [Pw-1:0]   p0_q, q0_q, p1_q, q1_q, den_q;

  assign ar = Dw'(in_req_i.a_real);
  assign ai = Dw'(in_req_i.a_imag);
  assign br = Dw'(in_req_i.b_real);
  assign bi = Dw'(in_req_i.b_imag);

  // Each product is a signed Dw by Dw multiply.
  assign ar_br = ar * br;
  assign ai_bi = ai * bi;
  assign ar_bi = ar * bi;
  assign ai_br = ai * br;
  assign br_br = br * br;
  assign bi_bi = bi * bi;

  always_comb begin
    p0 = '0; q0 = '0; p1 = '0; q1 = '0; den = '0;
    case (op_e'(in_req_i.opcode)) inside
      OP_ADD: begin
        p0 = Pw'(ar); q0 = Pw'(br); p1 = Pw'(ai); q1 = Pw'(bi);
      end
      // The compare works on the part differences, like a subtraction.
      OP_SUB, OP_EQ: begin
        p0 = Pw'(ar); q0 = -Pw'(br); p1 = Pw'(ai); q1 = -Pw'(bi);
      end
      OP_MUL: begin
        p0 = Pw'(ar_br); q0 = -Pw'(ai_bi);
        p1 = Pw'(ar_bi); q1 = Pw'(ai_br);
      end
      OP_DIV: begin
        p0 = Pw'(ar_br); q0 = Pw'(ai_bi);
        p1 = Pw'(ai_br); q1 = -Pw'(ar_bi);
        den = Pw'(br_br) + Pw'(bi_bi);
      end
      OP_CONJ: begin
        p0 = Pw'(ar); p1 = -Pw'(ai);
      end
      default: ;
    endcase
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = {op_q, p0_q + q0_q, p1_q + q1_q, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q <= in_req_i.opcode;
      p0_q <= p0; q0_q <= q0; p1_q <= p1; q1_q <= q1; den_q <= den;
    end
  end
endmodule
`default_nettype wire

[sv/cau_back.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Pipelined restoring divider, rounding, saturation and compare.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_back #(
  parameter int unsigned Dw = 32,
  parameter int unsigned Fb = 16,
  parameter int unsigned Pw = 2*Dw+2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [cau_pkg::TolWidth-1:0] tol_i,
  input  wire logic                         in_valid_i,
  input  wire logic [3*Pw+2:0]              in_data_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  output cau_pkg::res_t                     out_res_o,
  input  wire logic                         out_ready_i
);
  import cau_pkg::*;

  // Quotient bits: magnitude up to 2^(Pw) then Fb fraction bits, capped.
  localparam int unsigned Nq    = Pw + Fb;
  localparam int unsigned Steps = Nq;
  localparam int unsigned Mw    = Pw + Fb;
  localparam int unsigned Cw    = Dw + 2;

  typedef struct packed {
    logic [2:0]        op;
    logic              n0, n1;
    logic [Mw-1:0]     m0, m1;
    logic [Pw-1:0]     den;
    logic [Pw:0]       r0, r1;
    logic [Cw:0]       qt0, qt1;
  } stage_t;

  logic          adv;
  logic [Steps:0] vld_q;
  stage_t        st_q [Steps+1];
  stage_t        s_in;
  logic [2:0]    iop;
  logic signed [Pw-1:0] isum0, isum1;
  logic [Pw-1:0] iden;

  assign adv        = !vld_q[Steps] || out_ready_i;
  assign in_ready_o = adv;
  assign {iop, isum0, isum1, iden} = in_data_i;

  always_comb begin
    s_in.op    = iop;
    s_in.n0    = isum0[Pw-1];
    s_in.n1    = isum1[Pw-1];
    s_in.m0    = Mw'(isum0[Pw-1] ? -isum0 : isum0) << Fb;
    s_in.m1    = Mw'(isum1[Pw-1] ? -isum1 : isum1) << Fb;
    s_in.den   = iden;
    s_in.r0    = '0;
    s_in.r1    = '0;
    s_in.qt0   = '0;
    s_in.qt1   = '0;
  end

  // One quotient bit per stage for both parts; quotient saturates at the cap.
  function automatic void dstep(input logic [Pw:0] r, input logic mbit,
                                input logic [Pw-1:0] d, input logic [Cw:0] q,
                                output logic [Pw:0] ro, output logic [Cw:0] qo);
    logic [Pw+1:0] t;
    logic [Cw+1:0] qn;
    t  = {r, mbit};
    qn = {q, 1'b0};
    if (t >= (Pw+2)'(d)) begin
      t = t - (Pw+2)'(d);
      qn[0] = 1'b1;
    end
    ro = t[Pw:0];
    if (qn > (Cw+2)'(1) << (Dw+1)) qo = (Cw+1)'(1) << (Dw+1);
    else qo = qn[Cw:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Steps-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= s_in;
      for (int i = 1; i <= Steps; i++) begin
        logic [Pw:0] r0n, r1n;
        logic [Cw:0] q0n, q1n;
        dstep(st_q[i-1].r0, st_q[i-1].m0[Mw-i], st_q[i-1].den, st_q[i-1].qt0,
              r0n, q0n);
        dstep(st_q[i-1].r1, st_q[i-1].m1[Mw-i], st_q[i-1].den, st_q[i-1].qt1,
              r1n, q1n);
        st_q[i].op  <= st_q[i-1].op;
        st_q[i].n0  <= st_q[i-1].n0; st_q[i].n1 <= st_q[i-1].n1;
        st_q[i].m0  <= st_q[i-1].m0; st_q[i].m1 <= st_q[i-1].m1;
        st_q[i].den <= st_q[i-1].den;
        st_q[i].r0  <= r0n; st_q[i].r1 <= r1n;
        st_q[i].qt0 <= q0n; st_q[i].qt1 <= q1n;
      end
    end
  end

  // Final formatting of the last stage.
  function automatic logic [Dw:0] pack_sat(input logic neg, input logic [Mw-1:0] mag);
    logic [Mw-1:0] lim;
    logic [Dw-1:0] v;
    logic          ovf;
    lim = Mw'(1) << (Dw-1);
    ovf = 1'b0;
    if (neg) begin
      if (mag > lim) begin v = {1'b1, {(Dw-1){1'b0}}}; ovf = 1'b1; end
      else v = -Dw'(mag);
    end else begin
      if (mag > lim - 1'b1) begin v = {1'b0, {(Dw-1){1'b1}}}; ovf = 1'b1; end
      else v = Dw'(mag);
    end
    return {ovf, v};
  endfunction

  stage_t        last;
  logic [Mw-1:0] mag0, mag1, fl0, fl1, md0, md1, tol;
  logic [Dw:0]   pr, pi;
  logic          zden;

  always_comb begin
    last = st_q[Steps];
    mag0 = last.m0 >> Fb;
    mag1 = last.m1 >> Fb;
    md0  = '0;
    md1  = '0;
    tol  = (tol_i == '0) ? Mw'(1) : Mw'(tol_i);
    zden = (last.den == '0);
    out_res_o = '0;
    pr = '0;
    pi = '0;
    fl0 = '0;
    fl1 = '0;
    case (op_e'(last.op)) inside
      OP_ADD, OP_SUB, OP_CONJ: begin
        pr = pack_sat(last.n0, mag0);
        pi = pack_sat(last.n1, mag1);
      end
      OP_MUL: begin
        // Floor of the exact sum divided by 2^Fb: magnitude rounds up when negative.
        fl0 = (mag0 >> Fb) + Mw'(last.n0 && ((mag0 & ((Mw'(1) << Fb) - 1'b1)) != '0));
        fl1 = (mag1 >> Fb) + Mw'(last.n1 && ((mag1 & ((Mw'(1) << Fb) - 1'b1)) != '0));
        pr  = pack_sat(last.n0, fl0);
        pi  = pack_sat(last.n1, fl1);
      end
      OP_DIV: begin
        md0 = Mw'(last.qt0);
        md1 = Mw'(last.qt1);
        if (!zden) begin
          pr = pack_sat(last.n0, md0);
          pi = pack_sat(last.n1, md1);
        end
      end
      default: ;
    endcase
    out_res_o.res_real = 32'(signed'(pr[Dw-1:0]));
    out_res_o.res_imag = 32'(signed'(pi[Dw-1:0]));
    if (op_e'(last.op) == OP_EQ)
      out_res_o.are_equal = (mag0 < tol) && (mag1 < tol);
    if (op_e'(last.op) == OP_DIV && zden) out_res_o.status = ST_DIV0;
    else if (pr[Dw] || pi[Dw])            out_res_o.status = ST_OVF;
    else                                  out_res_o.status = ST_OK;
  end

  assign out_valid_o = vld_q[Steps];
endmodule
`default_nettype wire

[sv/complex_arith_unit_top.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit top level
// Complex ALU: add, subtract, multiply, divide, conjugate and compare.
// ----------------------------------------------------------------------------
// Path: front-end register, middle queue, divider pipeline, result queue.
// Throughput: one request per cycle when not stalled; the divider is a fully
// pipelined restoring array, one quotient bit per stage; all opcodes stream.
// Reset clears the tolerance register, all valid flags and both queues.
`default_nettype none
module complex_arith_unit_top #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  input  wire cau_pkg::req_t req_i,
  output logic               full,
  output logic               empty,
  input  wire logic          pop,
  output cau_pkg::res_t      res_o,
  input  wire logic          cfg_we_i,
  input  wire logic [30:0]   cfg_wdata_i
);
  import cau_pkg::*;

  // The working width is clamped to what the 32-bit fields can carry.
  localparam int unsigned Dw = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 8) ? 8 : DATA_WIDTH);
  localparam int unsigned Fb = (FRAC_BITS > 62) ? 62 : FRAC_BITS;
  localparam int unsigned Pw = 2*Dw + 2;
  localparam int unsigned Iw = 3*Pw + 3;
  localparam int unsigned Rw = $bits(res_t);

  logic [TolWidth-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Front end: operand products, registered once.
  logic          f_valid, f_ready;
  logic [Iw-1:0] f_data;

  // A short queue decouples the front end from the back-end pipeline.
  logic          q_full, q_empty, b_ready;
  logic [Iw-1:0] q_data;

  cau_front #(.Dw(Dw), .Pw(Pw)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (push),
    .in_req_i   (req_i),
    .in_ready_o (f_ready),
    .out_valid_o(f_valid),
    .out_data_o (f_data),
    .out_ready_i(!q_full)
  );
  assign full = !f_ready;

  cau_queue #(.Width(Iw), .Depth(2)) u_mid (
    .clk_i, .rst_ni,
    .push_i (f_valid),
    .data_i (f_data),
    .full_o (q_full),
    .pop_i  (b_ready),
    .data_o (q_data),
    .empty_o(q_empty)
  );

  logic  b_valid, o_full;
  res_t  b_res;

  cau_back #(.Dw(Dw), .Fb(Fb), .Pw(Pw)) u_back (
    .clk_i, .rst_ni,
    .tol_i      (tol_q),
    .in_valid_i (!q_empty),
    .in_data_i  (q_data),
    .in_ready_o (b_ready),
    .out_valid_o(b_valid),
    .out_res_o  (b_res),
    .out_ready_i(!o_full)
  );

  // Result queue: presents the oldest request's result to the consumer.
  logic [Rw-1:0] o_data;

  cau_queue #(.Width(Rw), .Depth(2)) u_out (
    .clk_i, .rst_ni,
    .push_i (b_valid),
    .data_i (b_res),
    .full_o (o_full),
    .pop_i  (pop),
    .data_o (o_data),
    .empty_o(empty)
  );
  assign res_o = res_t'(o_data);
endmodule
`default_nettype wire
